@@ hw/rtl/pmef_pkg.sv @@
// Package for the PS/2 mouse packet event queue.
// Shared types, sizes and operation codes; no dependencies.
package pmef_pkg;

    localparam int QUEUE_DEPTH = 64;            // power of two
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int COUNT_W     = 7;

    localparam logic [1:0] OP_AUX  = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    localparam logic [1:0] CMD_NOP = 2'd0;
    localparam logic [1:0] CMD_ENQ = 2'd1;
    localparam logic [1:0] CMD_POP = 2'd2;

    typedef struct packed {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [7:0]         buttons;
    } event_t;

    typedef struct packed {
        logic [1:0] kind;
        event_t     ev;
    } cmd_t;

    typedef struct packed {
        logic               event_valid;
        logic signed [15:0] out_dx;
        logic signed [15:0] out_dy;
        logic [7:0]         out_buttons;
        logic               event_dropped;
        logic [COUNT_W-1:0] queue_count;
        logic               event_ready;
    } result_t;

endpackage

@@ hw/rtl/pmef_front.sv @@
// Front end: assembles 3-byte PS/2 packets and classifies each transfer into a command.
// Depends on pmef_pkg.
module pmef_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           operation,
    input  logic [7:0]           aux_byte,
    input  logic signed [15:0]   push_dx,
    input  logic signed [15:0]   push_dy,
    input  logic [7:0]           push_buttons,
    output pmef_pkg::cmd_t       cmd
);
    import pmef_pkg::*;

    logic [1:0]  byte_index_reg, byte_index_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [7:0]  second_byte_reg, second_byte_next;
    logic [15:0] dy_raw;

    assign dy_raw = {{7{first_byte_reg[5]}}, first_byte_reg[5], aux_byte};

    always_comb
    begin
        byte_index_next  = byte_index_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        cmd.kind         = CMD_NOP;
        cmd.ev.dx        = push_dx;
        cmd.ev.dy        = push_dy;
        cmd.ev.buttons   = push_buttons;
        unique case (operation)
            OP_AUX:
            begin
                if (byte_index_reg == 2'd0)
                begin
                    if (aux_byte[3])
                    begin
                        first_byte_next = aux_byte;
                        byte_index_next = 2'd1;
                    end
                end
                else if (byte_index_reg == 2'd1)
                begin
                    second_byte_next = aux_byte;
                    byte_index_next  = 2'd2;
                end
                else
                begin
                    byte_index_next = 2'd0;
                    cmd.kind        = CMD_ENQ;
                    cmd.ev.dx       = {{7{first_byte_reg[4]}}, first_byte_reg[4],
                                       second_byte_reg};
                    cmd.ev.dy       = 16'd0 - dy_raw;
                    cmd.ev.buttons  = {5'd0, first_byte_reg[2:0]};
                end
            end
            OP_PUSH: cmd.kind = CMD_ENQ;
            OP_POP:  cmd.kind = CMD_POP;
            default: cmd.kind = CMD_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= 2'd0;
            first_byte_reg  <= 8'd0;
            second_byte_reg <= 8'd0;
        end
        else if (accept)
        begin
            byte_index_reg  <= byte_index_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
        end
    end

endmodule

@@ hw/rtl/pmef_cmd_queue.sv @@
// Two-entry command queue between front and back ends.
// Depends on pmef_pkg.
module pmef_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  pmef_pkg::cmd_t wr_cmd,
    output logic           full,
    input  logic           rd_en,
    output logic           empty,
    output pmef_pkg::cmd_t rd_cmd
);
    import pmef_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign rd_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/pmef_back.sv @@
// Back end: event ring memory, pointers, and the result register.
// Depends on pmef_pkg.
module pmef_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_avail,
    input  pmef_pkg::cmd_t    cmd,
    output logic              cmd_take,
    output logic              empty,
    input  logic              pop,
    output pmef_pkg::result_t res
);
    import pmef_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    event_t             ring_mem [QUEUE_DEPTH];
    event_t             rd_data_reg;
    logic               state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [PTR_W-1:0]   cnt, cnt_after;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    logic               slot_free, ring_full, wr_en, rd_en;

    assign empty     = !out_valid_reg;
    assign res       = out_reg;
    assign slot_free = !out_valid_reg || pop;
    assign cnt       = wp_reg - rp_reg;
    assign ring_full = cnt[PTR_W-1];
    assign cmd_take  = (state_reg == ST_IDLE) && cmd_avail && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        cnt_after      = cnt;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    out_next = '0;
                    unique case (cmd.kind)
                        CMD_ENQ:
                        begin
                            if (ring_full)
                                out_next.event_dropped = 1'b1;
                            else
                            begin
                                wr_en     = 1'b1;
                                wp_next   = wp_reg + 1'b1;
                                cnt_after = cnt + 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            if (cnt != '0)
                            begin
                                rd_en      = 1'b1;
                                rp_next    = rp_reg + 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                    out_next.queue_count = COUNT_W'(cnt_after);
                    out_next.event_ready = (cnt_after != '0);
                    if (state_next == ST_IDLE)
                        out_valid_next = 1'b1;
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    out_next             = '0;
                    out_next.event_valid = 1'b1;
                    out_next.out_dx      = rd_data_reg.dx;
                    out_next.out_dy      = rd_data_reg.dy;
                    out_next.out_buttons = rd_data_reg.buttons;
                    out_next.queue_count = COUNT_W'(cnt);
                    out_next.event_ready = (cnt != '0);
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[wp_reg[ADDR_W-1:0]] <= cmd.ev;
        if (rd_en)
            rd_data_reg <= ring_mem[rp_reg[ADDR_W-1:0]];
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/ps2_mouse_packet_event_fifo.sv @@
// Top level of the PS/2 mouse packet event queue.
// Depends on pmef_pkg, pmef_front, pmef_cmd_queue and pmef_back.
//
// Each transfer in (push while not full) yields exactly one result, taken by
// pop while not empty. With the back end free, a byte, push or no-op transfer
// has its result on the ports after passing through the command queue and the
// result register; a pop of a non-empty ring also passes through the registered
// read of the 64-entry event memory. The back end handles one command at a
// time and holds while a result is not taken; the two-entry command queue
// accepts new transfers meanwhile until it is full.
module ps2_mouse_packet_event_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 operation,
    input  logic [7:0]                 aux_byte,
    input  logic signed [15:0]         push_dx,
    input  logic signed [15:0]         push_dy,
    input  logic [7:0]                 push_buttons,
    output logic                       empty,
    input  logic                       pop,
    output logic                       event_valid,
    output logic signed [15:0]         out_dx,
    output logic signed [15:0]         out_dy,
    output logic [7:0]                 out_buttons,
    output logic                       event_dropped,
    output logic [pmef_pkg::COUNT_W-1:0] queue_count,
    output logic                       event_ready
);
    import pmef_pkg::*;

    cmd_t    front_cmd, q_cmd;
    result_t res;
    logic    accept, q_empty, cmd_take;

    assign accept = push && !full;

    pmef_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .aux_byte     (aux_byte),
        .push_dx      (push_dx),
        .push_dy      (push_dy),
        .push_buttons (push_buttons),
        .cmd          (front_cmd)
    );

    pmef_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd_en  (cmd_take),
        .empty  (q_empty),
        .rd_cmd (q_cmd)
    );

    pmef_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (!q_empty),
        .cmd       (q_cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign event_valid   = res.event_valid;
    assign out_dx        = res.out_dx;
    assign out_dy        = res.out_dy;
    assign out_buttons   = res.out_buttons;
    assign event_dropped = res.event_dropped;
    assign queue_count   = res.queue_count;
    assign event_ready   = res.event_ready;

endmodule

@@ hw/rtl/pmef_checker.sv @@
// Port-level checker for ps2_mouse_packet_event_fifo, attached by bind.
// Depends on pmef_pkg.
module pmef_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         empty,
    input logic                         pop,
    input logic                         event_valid,
    input logic                         event_dropped,
    input logic [pmef_pkg::COUNT_W-1:0] queue_count,
    input logic                         event_ready
);
    import pmef_pkg::*;

    a_ready_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (event_ready == (queue_count != '0)))
        else $error("event_ready disagrees with queue_count");

    a_pop_never_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_valid) |-> !event_dropped)
        else $error("result both popped and dropped an event");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (queue_count <= COUNT_W'(QUEUE_DEPTH)))
        else $error("queue_count above ring depth");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result withdrawn before transfer");

endmodule

bind ps2_mouse_packet_event_fifo pmef_checker u_pmef_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .event_valid   (event_valid),
    .event_dropped (event_dropped),
    .queue_count   (queue_count),
    .event_ready   (event_ready)
);
